@@ sv/pireg_pkg.sv @@
package pireg_pkg;

	localparam int unsigned CfgIdxW = 3;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_INT_GAIN    = 3'd0,
		CFG_PROP_GAIN   = 3'd1,
		CFG_LOWER_LIMIT = 3'd2,
		CFG_UPPER_LIMIT = 3'd3,
		CFG_FREEZE      = 3'd4,
		CFG_INT_STEP    = 3'd5
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_P,
		ST_MUL_I,
		ST_MUL_S,
		ST_UPDATE,
		ST_OUTPUT
	} state_t;

	typedef enum logic [1:0] {
		OPA_ERR,
		OPA_PROD
	} opa_sel_t;

	typedef enum logic [1:0] {
		OPB_ZERO,
		OPB_PROP,
		OPB_INT,
		OPB_STEP
	} opb_sel_t;

	typedef struct packed {
		opa_sel_t opa;
		opb_sel_t opb;
	} mul_ctrl_t;

endpackage

@@ sv/pi_regulator_antiwindup.sv @@
// sequence: an accepted beat is registered, then MUL_P, MUL_I, MUL_S, UPDATE and OUTPUT,
//   which waits for a free output; a new beat is taken only in IDLE, as the single shared
//   32x16 multiplier runs the P product and the two integral products one after another
// reset: arst_n clears the configuration registers, the integral and the last output to zero
module pi_regulator_antiwindup (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] setpoint,
	input  logic signed [15:0] measured,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] drive_output,
	output logic signed [31:0] integral_value,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	pireg_pkg::state_t    state_q, state_d;
	pireg_pkg::mul_ctrl_t mul_ctrl;

	logic [15:0]        int_gain_q, prop_gain_q, step_q;
	logic signed [31:0] lower_q, upper_q;
	logic               freeze_q;

	logic signed [16:0] err_q;
	logic signed [31:0] prop_q, integ_q, last_q;
	logic signed [31:0] drive_q, integ_out_q;
	logic               out_valid_q;

	logic [31:0]        err32, mul_a, prod;
	logic [15:0]        mul_b;
	logic signed [31:0] cand, integ_next, sum, clamped;
	logic               in_lim, opposing, do_update, cand_pos, cand_neg, out_load;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			int_gain_q  <= '0;
			prop_gain_q <= '0;
			lower_q     <= '0;
			upper_q     <= '0;
			freeze_q    <= 1'b0;
			step_q      <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				pireg_pkg::CFG_INT_GAIN:    int_gain_q  <= cfg_data[15:0];
				pireg_pkg::CFG_PROP_GAIN:   prop_gain_q <= cfg_data[15:0];
				pireg_pkg::CFG_LOWER_LIMIT: lower_q     <= cfg_data;
				pireg_pkg::CFG_UPPER_LIMIT: upper_q     <= cfg_data;
				pireg_pkg::CFG_FREEZE:      freeze_q    <= cfg_data[0];
				pireg_pkg::CFG_INT_STEP:    step_q      <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pireg_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		mul_ctrl.opa = pireg_pkg::OPA_ERR;
		mul_ctrl.opb = pireg_pkg::OPB_ZERO;
		in_ready     = 1'b0;
		out_load     = 1'b0;
		case (state_q)
			pireg_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) state_d = pireg_pkg::ST_MUL_P;
			end
			pireg_pkg::ST_MUL_P: begin
				mul_ctrl.opb = pireg_pkg::OPB_PROP;
				state_d      = pireg_pkg::ST_MUL_I;
			end
			pireg_pkg::ST_MUL_I: begin
				mul_ctrl.opb = pireg_pkg::OPB_INT;
				state_d      = pireg_pkg::ST_MUL_S;
			end
			pireg_pkg::ST_MUL_S: begin
				mul_ctrl.opa = pireg_pkg::OPA_PROD;
				mul_ctrl.opb = pireg_pkg::OPB_STEP;
				state_d      = pireg_pkg::ST_UPDATE;
			end
			pireg_pkg::ST_UPDATE: begin
				state_d = pireg_pkg::ST_OUTPUT;
			end
			pireg_pkg::ST_OUTPUT: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = pireg_pkg::ST_IDLE;
				end
			end
			default: state_d = pireg_pkg::ST_IDLE;
		endcase
	end

	// shared multiplier
	assign err32 = {{15{err_q[16]}}, err_q};

	always_comb begin
		case (mul_ctrl.opa)
			pireg_pkg::OPA_PROD: mul_a = prod;
			default:             mul_a = err32;
		endcase
		case (mul_ctrl.opb)
			pireg_pkg::OPB_PROP: mul_b = prop_gain_q;
			pireg_pkg::OPB_INT:  mul_b = int_gain_q;
			pireg_pkg::OPB_STEP: mul_b = step_q;
			default:             mul_b = '0;
		endcase
	end

	pireg_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (prod)
	);

	// anti-windup integral update
	assign in_lim    = (last_q >= lower_q) && (last_q <= upper_q);
	assign opposing  = (!err_q[16] && (err_q != '0) && integ_q[31]) ||
		(err_q[16] && !integ_q[31] && (integ_q != '0));
	assign do_update = (!freeze_q && in_lim) || opposing;
	assign cand      = integ_q + $signed(prod);
	assign cand_pos  = !cand[31] && (cand != '0);
	assign cand_neg  = cand[31];

	always_comb begin
		integ_next = integ_q;
		if (do_update) begin
			if (cand_pos) begin
				if (cand <= upper_q) integ_next = cand;
				else if (upper_q == '0) integ_next = '0;
			end else if (cand_neg) begin
				if (cand >= lower_q) integ_next = cand;
				else if (lower_q == '0) integ_next = '0;
			end
		end
	end

	// output sum and clamp
	assign sum = integ_q + prop_q;

	always_comb begin
		if (sum > upper_q) clamped = upper_q;
		else if (sum < lower_q) clamped = lower_q;
		else clamped = sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
			last_q  <= '0;
		end else begin
			if (state_q == pireg_pkg::ST_UPDATE) integ_q <= integ_next;
			if (out_load) last_q <= clamped;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) err_q <= 17'(setpoint) - 17'(measured);
		if (state_q == pireg_pkg::ST_MUL_I) prop_q <= $signed(prod);
		if (out_load) begin
			drive_q     <= clamped;
			integ_out_q <= integ_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid      = out_valid_q;
	assign drive_output   = drive_q;
	assign integral_value = integ_out_q;

	// checks
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == pireg_pkg::ST_MUL_P)
		else $error("accepted beat did not start the sequence");

	a_integ_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pireg_pkg::ST_UPDATE && integ_next != integ_q |=>
		integ_q == '0 || (integ_q > 0 && integ_q <= upper_q) ||
		(integ_q < 0 && integ_q >= lower_q))
		else $error("integral left the limits");

	a_drive_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && lower_q <= upper_q |=>
		drive_q >= lower_q && drive_q <= upper_q)
		else $error("output outside the limits");

	a_last_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> last_q == drive_q && integ_out_q == integ_q)
		else $error("stored output differs from result");

endmodule

@@ sv/pireg_mul.sv @@
module pireg_mul (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [15:0] b,
	output logic [31:0] p_q
);

	logic [31:0] full;

	// product wraps at 32 bits
	assign full = a * {16'd0, b};

	always_ff @(posedge clk) begin
		p_q <= full;
	end

endmodule
